[src/deq_pkg.sv]
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int FILL_W    = 5;
    localparam int STAT_W    = 2;
    localparam int QDEPTH    = 2;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     store;
        logic                     at_front;
        logic                     remove;
        logic                     query;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

[src/deq_ram.sv]
`default_nettype none

module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_W,
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/deq_front.sv]
`default_nettype none

module deq_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [deq_pkg::REQ_W-1:0]         req_type,
    input  wire logic signed [deq_pkg::DATA_W-1:0] value,
    output logic                                   busy,
    output logic                                   cmd_valid,
    output deq_pkg::cmd_t                          cmd,
    input  wire logic                              cmd_pop
);

    localparam int QAW = $clog2(deq_pkg::QDEPTH);
    localparam int QCW = $clog2(deq_pkg::QDEPTH + 1);

    deq_pkg::cmd_t       q_reg [deq_pkg::QDEPTH];
    logic [QAW-1:0]      wptr_reg;
    logic [QAW-1:0]      rptr_reg;
    logic [QCW-1:0]      cnt_reg;
    logic [QCW-1:0]      cnt_next;
    deq_pkg::cmd_t       cls;
    logic                push;

    function automatic logic [QAW-1:0] qinc(input logic [QAW-1:0] p);
        return (p == QAW'(deq_pkg::QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    // decode the request into its class
    always_comb
    begin
        cls          = '0;
        cls.value    = value;
        case (req_type)
            deq_pkg::REQ_APPEND: cls.store = 1'b1;
            deq_pkg::REQ_PUSH:
            begin
                cls.store    = 1'b1;
                cls.at_front = 1'b1;
            end
            deq_pkg::REQ_REMOVE: cls.remove = 1'b1;
            deq_pkg::REQ_QUERY:  cls.query  = 1'b1;
            default:             cls.query  = 1'b1;
        endcase
    end

    assign busy      = (cnt_reg == QCW'(deq_pkg::QDEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= qinc(wptr_reg);
            end
            if (cmd_pop)
            begin
                rptr_reg <= qinc(rptr_reg);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

[src/deq_back.sv]
`default_nettype none

module deq_back #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cmd_valid,
    input  wire deq_pkg::cmd_t                      cmd,
    output logic                                    cmd_pop,
    output logic                                    done,
    output logic signed [deq_pkg::DATA_W-1:0]       result_value,
    output logic                                    found,
    output logic        [deq_pkg::FILL_W-1:0]       fill_count,
    output logic        [deq_pkg::STAT_W-1:0]       status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]                   state_reg,  state_next;
    logic [AW-1:0]                head_reg,   head_next;
    logic [CW-1:0]                count_reg,  count_next;
    logic [AW-1:0]                ptr_reg,    ptr_next;
    logic [CW-1:0]                left_reg,   left_next;
    logic [deq_pkg::DATA_W-1:0]   key_reg,    key_next;
    logic                         done_reg,   done_next;
    logic [deq_pkg::DATA_W-1:0]   resv_reg,   resv_next;
    logic                         found_reg,  found_next;
    logic [deq_pkg::FILL_W-1:0]   fill_reg;
    logic [deq_pkg::STAT_W-1:0]   stat_reg,   stat_next;

    logic                         we;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;
    logic [deq_pkg::DATA_W-1:0]   rdata;
    logic [AW:0]                  tail_sum;
    logic [AW-1:0]                tail;
    logic [AW-1:0]                head_dec;
    logic                         full;
    logic                         empty;

    function automatic logic [AW-1:0] rinc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign tail_sum = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign tail     = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                   : AW'(tail_sum);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        resv_next  = '0;
        found_next = 1'b0;
        stat_next  = deq_pkg::ST_OK;
        we         = 1'b0;
        waddr      = tail;
        raddr      = head_reg;
        cmd_pop    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.store)
                    begin
                        done_next = 1'b1;
                        if (full)
                        begin
                            stat_next = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (cmd.at_front)
                            begin
                                waddr     = head_dec;
                                head_next = head_dec;
                            end
                        end
                    end
                    else if (cmd.remove)
                    begin
                        if (empty)
                        begin
                            done_next = 1'b1;
                            resv_next = '1;
                            stat_next = deq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        if (empty)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            key_next   = cmd.value;
                            ptr_next   = head_reg;
                            left_next  = count_reg - CW'(1);
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_READ:
            begin
                done_next  = 1'b1;
                resv_next  = rdata;
                head_next  = rinc(head_reg);
                count_next = count_reg - CW'(1);
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // next entry is fetched while this one is compared
                raddr    = rinc(ptr_reg);
                ptr_next = rinc(ptr_reg);
                if (rdata == key_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (left_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    left_next = left_reg - CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        left_reg <= left_next;
        key_reg  <= key_next;
        if (done_next)
        begin
            resv_reg  <= resv_next;
            found_reg <= found_next;
            fill_reg  <= deq_pkg::FILL_W'(count_next);
            stat_reg  <= stat_next;
        end
    end

    assign done         = done_reg;
    assign result_value = resv_reg;
    assign found        = found_reg;
    assign fill_count   = fill_reg;
    assign status       = stat_reg;

endmodule

`default_nettype wire

[src/deque_with_membership_search.sv]
// Double-ended queue of DEPTH signed words in a ring, with a membership search.
// A request is taken when start is high and busy is low; busy rises only while
// the two-beat command queue in front of the execution engine is full. Every
// request gives exactly one result beat, shown for one cycle with done high;
// the receiver cannot stall it. An append, a push or any rejected request is
// finished directly from the idle state; a removal takes one read of the ring
// memory; a query compares k held words (k at most the fill count), one per
// cycle from the front, stopping at the first match. A result appears in the
// cycle after the engine finishes. There is no clearing pass after reset.
`default_nettype none

module deque_with_membership_search #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [deq_pkg::REQ_W-1:0]         req_type,
    input  wire logic signed [deq_pkg::DATA_W-1:0] value,
    output logic                                   done,
    output logic signed [deq_pkg::DATA_W-1:0]      result_value,
    output logic                                   found,
    output logic        [deq_pkg::FILL_W-1:0]      fill_count,
    output logic        [deq_pkg::STAT_W-1:0]      status
);

    logic          cmd_valid;
    logic          cmd_pop;
    deq_pkg::cmd_t cmd;

    deq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .value     (value),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .done         (done),
        .result_value (result_value),
        .found        (found),
        .fill_count   (fill_count),
        .status       (status)
    );

endmodule

`default_nettype wire

[src/deq_checker.sv]
`default_nettype none

module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         done,
    input wire logic [deq_pkg::DATA_W-1:0]   result_value,
    input wire logic                         found,
    input wire logic [deq_pkg::FILL_W-1:0]   fill_count,
    input wire logic [deq_pkg::STAT_W-1:0]   status
);

    localparam logic [deq_pkg::FILL_W-1:0] FULL_FILL = deq_pkg::FILL_W'(DEPTH);

    a_no_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == deq_pkg::ST_OK || status == deq_pkg::ST_FULL ||
                  status == deq_pkg::ST_EMPTY))
        else $error("undefined status code");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == deq_pkg::ST_EMPTY |->
            result_value == '1 && fill_count == '0 && !found)
        else $error("bad beat for removal from empty store");

    a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == deq_pkg::ST_FULL |->
            fill_count == FULL_FILL && result_value == '0 && !found)
        else $error("bad beat for dropped word");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> status == deq_pkg::ST_OK && fill_count != '0 &&
            result_value == '0)
        else $error("found set on a beat that is not a hit");

endmodule

bind deque_with_membership_search deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .done         (done),
    .result_value (result_value),
    .found        (found),
    .fill_count   (fill_count),
    .status       (status)
);

`default_nettype wire

[verif/tb_deque_with_membership_search.sv]
`default_nettype none

module tb_deque_with_membership_search;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = deq_pkg::DEPTH_DEF;

    typedef struct packed {
        logic signed [deq_pkg::DATA_W-1:0] result_value;
        logic                              found;
        logic [deq_pkg::FILL_W-1:0]        fill_count;
        logic [deq_pkg::STAT_W-1:0]        status;
    } reply_t;

    class deque_shadow;
        logic signed [deq_pkg::DATA_W-1:0] ring [RING];
        int head;
        int count;
        int errors;
        reply_t owed_replies[$];

        function new();
            head = 0;
            count = 0;
            errors = 0;
        endfunction

        function logic signed [deq_pkg::DATA_W-1:0] any_held();
            return ring[(head + $urandom_range(0, count - 1)) % RING];
        endfunction

        function void log_request(logic [deq_pkg::REQ_W-1:0] kind,
                                  logic signed [deq_pkg::DATA_W-1:0] word);
            reply_t r;
            r.result_value = '0;
            r.found = 1'b0;
            r.status = deq_pkg::ST_OK;
            case (kind)
                deq_pkg::REQ_APPEND:
                begin
                    if (count >= RING)
                        r.status = deq_pkg::ST_FULL;
                    else
                    begin
                        ring[(head + count) % RING] = word;
                        count++;
                    end
                end
                deq_pkg::REQ_PUSH:
                begin
                    if (count >= RING)
                        r.status = deq_pkg::ST_FULL;
                    else
                    begin
                        head = (head + RING - 1) % RING;
                        ring[head] = word;
                        count++;
                    end
                end
                deq_pkg::REQ_REMOVE:
                begin
                    if (count == 0)
                    begin
                        r.result_value = -1;
                        r.status = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        r.result_value = ring[head];
                        head = (head + 1) % RING;
                        count--;
                    end
                end
                default:
                begin
                    for (int i = 0; i < count; i++)
                        if (ring[(head + i) % RING] == word)
                            r.found = 1'b1;
                end
            endcase
            r.fill_count = count[deq_pkg::FILL_W-1:0];
            owed_replies.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t exp;
            if (owed_replies.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                errors++;
                return;
            end
            exp = owed_replies.pop_front();
            if (got.result_value !== exp.result_value)
            begin
                $error("result_value: expected %0d, got %0d", exp.result_value, got.result_value);
                errors++;
            end
            if (got.found !== exp.found)
            begin
                $error("found: expected %0d, got %0d", exp.found, got.found);
                errors++;
            end
            if (got.fill_count !== exp.fill_count)
            begin
                $error("fill_count: expected %0d, got %0d", exp.fill_count, got.fill_count);
                errors++;
            end
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [deq_pkg::REQ_W-1:0]         req_type = '0;
    logic signed [deq_pkg::DATA_W-1:0] value = '0;
    logic                              done;
    logic signed [deq_pkg::DATA_W-1:0] result_value;
    logic                              found;
    logic [deq_pkg::FILL_W-1:0]        fill_count;
    logic [deq_pkg::STAT_W-1:0]        status;

    deque_shadow shadow = new();
    bit idle_on = 1'b1;

    always #5 clk = ~clk;

    deque_with_membership_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .found        (found),
        .fill_count   (fill_count),
        .status       (status)
    );

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_reply('{result_value, found, fill_count, status});
    end

    task automatic issue(input logic [deq_pkg::REQ_W-1:0] kind,
                         input logic signed [deq_pkg::DATA_W-1:0] word);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= kind;
        value <= word;
        do @(posedge clk); while (busy);
        shadow.log_request(kind, word);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (shadow.owed_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [deq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 8)) - 4;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [deq_pkg::DATA_W-1:0] probe_word();
        if (shadow.count > 0 && $urandom_range(0, 99) < 60)
            return shadow.any_held();
        return pick_word();
    endfunction

    initial
    begin
        int issued;
        int mode;
        int plen;
        int r;
        bit paused;
        logic [deq_pkg::REQ_W-1:0] kind;

        issued = 0;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store corners, extremes, search hit and miss
        issue(deq_pkg::REQ_REMOVE, 32'sd5);
        issue(deq_pkg::REQ_QUERY, 32'sd0);
        issue(deq_pkg::REQ_APPEND, 32'sh8000_0000);
        issue(deq_pkg::REQ_PUSH, 32'sh7fff_ffff);
        issue(deq_pkg::REQ_QUERY, 32'sh8000_0000);
        issue(deq_pkg::REQ_QUERY, 32'sh7fff_ffff);
        issue(deq_pkg::REQ_QUERY, 32'sd0);
        issue(deq_pkg::REQ_APPEND, -32'sd1);
        issue(deq_pkg::REQ_PUSH, 32'sd0);
        issue(deq_pkg::REQ_REMOVE, 32'sd0);
        issue(deq_pkg::REQ_REMOVE, 32'sd0);
        issue(deq_pkg::REQ_REMOVE, 32'sd0);
        issue(deq_pkg::REQ_REMOVE, 32'sd0);
        issue(deq_pkg::REQ_REMOVE, 32'sd0);
        issue(deq_pkg::REQ_QUERY, -32'sd1);

        // phases: fill toward full, drain toward empty, mixed
        while (issued < 900)
        begin
            mode = $urandom_range(0, 2);
            plen = $urandom_range(15, 60);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < plen; n++)
            begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: kind = r < 40 ? deq_pkg::REQ_APPEND : r < 75 ? deq_pkg::REQ_PUSH
                            : r < 85 ? deq_pkg::REQ_REMOVE : deq_pkg::REQ_QUERY;
                    1: kind = r < 10 ? deq_pkg::REQ_APPEND : r < 20 ? deq_pkg::REQ_PUSH
                            : r < 75 ? deq_pkg::REQ_REMOVE : deq_pkg::REQ_QUERY;
                    default: kind = r < 25 ? deq_pkg::REQ_APPEND : r < 50 ? deq_pkg::REQ_PUSH
                                  : r < 75 ? deq_pkg::REQ_REMOVE : deq_pkg::REQ_QUERY;
                endcase
                issue(kind, kind == deq_pkg::REQ_QUERY ? probe_word() : pick_word());
                issued++;
            end
            if (!paused && issued >= 450)
            begin
                settle();
                paused = 1'b1;
            end
        end
        idle_on = 1'b1;

        settle();
        repeat (40) @(posedge clk);
        if (shadow.errors == 0 && shadow.owed_replies.size() == 0)
            $display("tb_deque_with_membership_search: done, clean");
        else
            $display("tb_deque_with_membership_search: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_deque_with_membership_search: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/deq_pkg.sv
src/deq_ram.sv
src/deq_front.sv
src/deq_back.sv
src/deque_with_membership_search.sv
src/deq_checker.sv
verif/tb_deque_with_membership_search.sv
